// File: rtl/core/qte_pkg.sv
// shared constants, widths and the arctangent table for the quaternion to euler core
// used by qte_cordic, qte_isqrt and quaternion_to_euler_angles_core
`default_nettype none
package qte_pkg;

  localparam int CordicStepsDef = 14;
  localparam int AtanLen        = 24;
  localparam int SqrtSteps      = 32;
  localparam int ProdW          = 32;
  localparam int SumW           = 35;
  localparam int ArgW           = 34;
  localparam int DataW          = 38;
  localparam int ZW             = 34;
  localparam int RootW          = 64;
  localparam int RootOutW       = 32;

  localparam logic signed [ZW-1:0]   PiQ30     = ZW'(64'sd3373259426);
  localparam logic signed [ZW-1:0]   HalfPiQ30 = ZW'(64'sd1686629713);
  localparam logic signed [ZW-1:0]   RoundQ30  = ZW'(64'sd65536);
  localparam logic signed [15:0]     PiQ13     = 16'sd25736;
  localparam logic signed [15:0]     HalfPiQ13 = 16'sd12868;
  localparam logic signed [SumW-1:0] OneQ28    = SumW'(64'sd268435456);

  // atan(2^-i) in q.30
  function automatic logic [29:0] atan_q30(input int unsigned i);
    logic [29:0] r;
    case (i)
      0:       r = 30'd843314857;
      1:       r = 30'd497837829;
      2:       r = 30'd263043837;
      3:       r = 30'd133525159;
      4:       r = 30'd67021687;
      5:       r = 30'd33543516;
      6:       r = 30'd16775851;
      7:       r = 30'd8388437;
      8:       r = 30'd4194283;
      9:       r = 30'd2097149;
      10:      r = 30'd1048576;
      11:      r = 30'd524288;
      12:      r = 30'd262144;
      13:      r = 30'd131072;
      14:      r = 30'd65536;
      15:      r = 30'd32768;
      16:      r = 30'd16384;
      17:      r = 30'd8192;
      18:      r = 30'd4096;
      19:      r = 30'd2048;
      20:      r = 30'd1024;
      21:      r = 30'd512;
      22:      r = 30'd256;
      23:      r = 30'd128;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

  // q.30 angle to 13 fraction bits, round half up, then clamp
  function automatic logic signed [15:0] to_q13(input logic signed [ZW-1:0] z,
                                                input logic signed [15:0] lim);
    logic signed [ZW-1:0] r;
    logic signed [ZW-1:0] l;
    r = (z + RoundQ30) >>> 17;
    l = ZW'(lim);
    if (r > l) begin
      r = l;
    end
    if (r < -l) begin
      r = -l;
    end
    return r[15:0];
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/qte_cordic.sv
// pipelined vectoring cordic atan2, one iteration per register stage
// depends on qte_pkg
`default_nettype none
module qte_cordic
  import qte_pkg::*;
#(
  parameter int Steps = CordicStepsDef
) (
  input  wire logic                    clk_i,
  input  wire logic                    en_i,
  input  wire logic signed [DataW-1:0] y_i,
  input  wire logic signed [DataW-1:0] x_i,
  output logic signed [ZW-1:0]         z_o
);

  logic signed [DataW-1:0] x_q    [Steps+1];
  logic signed [DataW-1:0] y_q    [Steps+1];
  logic signed [ZW-1:0]    z_q    [Steps+1];
  logic signed [ZW-1:0]    off_q  [Steps+1];
  logic                    zero_q [Steps+1];
  logic signed [ZW-1:0]    z_out_q;

  // quadrant fold
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero_q[0] <= (x_i == '0) && (y_i == '0);
      z_q[0]    <= '0;
      if (x_i < 0) begin
        x_q[0]   <= -x_i;
        y_q[0]   <= -y_i;
        off_q[0] <= (y_i >= 0) ? PiQ30 : -PiQ30;
      end else begin
        x_q[0]   <= x_i;
        y_q[0]   <= y_i;
        off_q[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < Steps; i++) begin : g_step
    logic signed [DataW-1:0] dx;
    logic signed [DataW-1:0] dy;
    logic signed [ZW-1:0]    ang;
    assign dx  = y_q[i] >>> i;
    assign dy  = x_q[i] >>> i;
    assign ang = ZW'(atan_q30(i));
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        zero_q[i+1] <= zero_q[i];
        off_q[i+1]  <= off_q[i];
        if (y_q[i] > 0) begin
          x_q[i+1] <= x_q[i] + dx;
          y_q[i+1] <= y_q[i] - dy;
          z_q[i+1] <= z_q[i] + ang;
        end else begin
          x_q[i+1] <= x_q[i] - dx;
          y_q[i+1] <= y_q[i] + dy;
          z_q[i+1] <= z_q[i] - ang;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      z_out_q <= zero_q[Steps] ? '0 : z_q[Steps] + off_q[Steps];
    end
  end

  assign z_o = z_out_q;

endmodule
`default_nettype wire

// File: rtl/core/qte_isqrt.sv
// pipelined integer square root, one digit recurrence step per register stage
// depends on qte_pkg
`default_nettype none
module qte_isqrt
  import qte_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                en_i,
  input  wire logic [RootW-1:0]    v_i,
  output logic      [RootOutW-1:0] res_o
);

  logic [RootW-1:0] v_q [SqrtSteps];
  logic [RootW-1:0] r_q [SqrtSteps];

  for (genvar k = 0; k < SqrtSteps; k++) begin : g_step
    logic [RootW-1:0] v_in;
    logic [RootW-1:0] r_in;
    logic [RootW-1:0] bitv;
    logic [RootW-1:0] trial;
    if (k == 0) begin : g_first
      assign v_in = v_i;
      assign r_in = '0;
    end else begin : g_next
      assign v_in = v_q[k-1];
      assign r_in = r_q[k-1];
    end
    assign bitv  = RootW'(1) << (RootW - 2 - 2 * k);
    assign trial = r_in + bitv;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (v_in >= trial) begin
          v_q[k] <= v_in - trial;
          r_q[k] <= (r_in >> 1) + bitv;
        end else begin
          v_q[k] <= v_in;
          r_q[k] <= r_in >> 1;
        end
      end
    end
  end

  assign res_o = r_q[SqrtSteps-1][RootOutW-1:0];

endmodule
`default_nettype wire

// File: rtl/core/quaternion_to_euler_angles_core.sv
// zyx euler angles from a q1.14 quaternion, fully pipelined
// stages in order: products, sums, 32 root steps, cordic, output
// throughput one item per cycle; a stalled output freezes the whole pipeline
// reset clears the valid bits only; depends on qte_pkg, qte_isqrt, qte_cordic
`default_nettype none
module quaternion_to_euler_angles_core
  import qte_pkg::*;
#(
  parameter int CORDIC_STEPS = CordicStepsDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic signed [15:0] quat_w_i,
  input  wire logic signed [15:0] quat_x_i,
  input  wire logic signed [15:0] quat_y_i,
  input  wire logic signed [15:0] quat_z_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [15:0]      roll_angle_o,
  output logic signed [14:0]      pitch_angle_o,
  output logic signed [15:0]      yaw_angle_o,
  output logic                    sqrt_clamped_o
);

  localparam int Lat      = CORDIC_STEPS + 37;
  localparam int ClampDly = SqrtSteps + CORDIC_STEPS + 2;

  logic [Lat-1:0] valid_q;
  logic           en;

  assign en         = !valid_q[Lat-1] || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[Lat-2:0], in_valid_i};
    end
  end

  // products
  logic signed [ProdW-1:0] wx_q, yz_q, xx_q, yy_q, zz_q, wz_q, xy_q, wy_q, xz_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      wx_q <= quat_w_i * quat_x_i;
      yz_q <= quat_y_i * quat_z_i;
      xx_q <= quat_x_i * quat_x_i;
      yy_q <= quat_y_i * quat_y_i;
      zz_q <= quat_z_i * quat_z_i;
      wz_q <= quat_w_i * quat_z_i;
      xy_q <= quat_x_i * quat_y_i;
      wy_q <= quat_w_i * quat_y_i;
      xz_q <= quat_x_i * quat_z_i;
    end
  end

  // sums
  logic signed [SumW-1:0] s_d, a_d, b_d;
  logic signed [SumW-1:0] roll_y_q, roll_x_q, yaw_y_q, yaw_x_q;
  logic        [ArgW-1:0] a_q, b_q;
  logic                   clamp_q;

  assign s_d = SumW'(wy_q) - SumW'(xz_q);
  assign a_d = OneQ28 + (s_d <<< 1);
  assign b_d = OneQ28 - (s_d <<< 1);

  always_ff @(posedge clk_i) begin
    if (en) begin
      roll_y_q <= (SumW'(wx_q) + SumW'(yz_q)) <<< 1;
      roll_x_q <= OneQ28 - ((SumW'(xx_q) + SumW'(yy_q)) <<< 1);
      yaw_y_q  <= (SumW'(wz_q) + SumW'(xy_q)) <<< 1;
      yaw_x_q  <= OneQ28 - ((SumW'(yy_q) + SumW'(zz_q)) <<< 1);
      a_q      <= a_d[SumW-1] ? '0 : a_d[ArgW-1:0];
      b_q      <= b_d[SumW-1] ? '0 : b_d[ArgW-1:0];
      clamp_q  <= a_d[SumW-1] || b_d[SumW-1];
    end
  end

  // pitch roots and angle
  logic [RootOutW-1:0]  ra, rb;
  logic signed [ZW-1:0] pitch_z, roll_z, yaw_z;

  qte_isqrt u_sqrt_a (
    .clk_i (clk_i),
    .en_i  (en),
    .v_i   ({(RootW - ArgW - 16)'(0), a_q, 16'd0}),
    .res_o (ra)
  );

  qte_isqrt u_sqrt_b (
    .clk_i (clk_i),
    .en_i  (en),
    .v_i   ({(RootW - ArgW - 16)'(0), b_q, 16'd0}),
    .res_o (rb)
  );

  qte_cordic #(.Steps(CORDIC_STEPS)) u_pitch (
    .clk_i (clk_i),
    .en_i  (en),
    .y_i   (DataW'(ra)),
    .x_i   (DataW'(rb)),
    .z_o   (pitch_z)
  );

  qte_cordic #(.Steps(CORDIC_STEPS)) u_roll (
    .clk_i (clk_i),
    .en_i  (en),
    .y_i   (DataW'(roll_y_q)),
    .x_i   (DataW'(roll_x_q)),
    .z_o   (roll_z)
  );

  qte_cordic #(.Steps(CORDIC_STEPS)) u_yaw (
    .clk_i (clk_i),
    .en_i  (en),
    .y_i   (DataW'(yaw_y_q)),
    .x_i   (DataW'(yaw_x_q)),
    .z_o   (yaw_z)
  );

  // align roll, yaw and the clamp flag with pitch
  logic signed [ZW-1:0] roll_dly_q [SqrtSteps];
  logic signed [ZW-1:0] yaw_dly_q  [SqrtSteps];
  logic [ClampDly-1:0]  clamp_dly_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      roll_dly_q[0] <= roll_z;
      yaw_dly_q[0]  <= yaw_z;
      for (int j = 1; j < SqrtSteps; j++) begin
        roll_dly_q[j] <= roll_dly_q[j-1];
        yaw_dly_q[j]  <= yaw_dly_q[j-1];
      end
      clamp_dly_q <= {clamp_dly_q[ClampDly-2:0], clamp_q};
    end
  end

  // rounding and output register
  logic signed [ZW-1:0] pitch_full;
  logic signed [15:0]   pitch_r;
  logic signed [15:0]   roll_q, yaw_q;
  logic signed [14:0]   pitch_q;
  logic                 clamped_q;

  assign pitch_full = (pitch_z <<< 1) - HalfPiQ30;
  assign pitch_r    = to_q13(pitch_full, HalfPiQ13);

  always_ff @(posedge clk_i) begin
    if (en) begin
      roll_q    <= to_q13(roll_dly_q[SqrtSteps-1], PiQ13);
      yaw_q     <= to_q13(yaw_dly_q[SqrtSteps-1], PiQ13);
      pitch_q   <= pitch_r[14:0];
      clamped_q <= clamp_dly_q[ClampDly-1];
    end
  end

  assign out_valid_o    = valid_q[Lat-1];
  assign roll_angle_o   = roll_q;
  assign pitch_angle_o  = pitch_q;
  assign yaw_angle_o    = yaw_q;
  assign sqrt_clamped_o = clamped_q;

endmodule
`default_nettype wire
